FILE: rtl/arbd_pkg.sv
// Shared types, constants and codes for the alpha run/level block decoder.
`timescale 1ns / 1ps
`default_nettype none
package arbd_pkg;

  localparam int BLK_SIZE  = 128;             // coefficients in one block
  localparam int LANES     = 8;               // bytes in one half row
  localparam int WORDS     = BLK_SIZE / LANES; // half rows in one block
  localparam int WORD_W    = $clog2(WORDS);
  localparam int POS_W     = $clog2(BLK_SIZE) + 1; // holds 0..128
  localparam int LANE_W    = $clog2(LANES);
  localparam int BYTE_W    = 8;
  localparam logic [BYTE_W-1:0] ALPHA_INIT = 8'hFF;
  localparam logic [3:0] MAX_LEN = 4'd8;

  typedef enum logic [3:0] {
    PH_RUN0   = 4'd0,
    PH_RUN1   = 4'd1,
    PH_RUN11  = 4'd2,
    PH_RSHORT = 4'd3,
    PH_RLONG  = 4'd4,
    PH_LVL0   = 4'd5,
    PH_LSIGN1 = 4'd6,
    PH_LVL00  = 4'd7,
    PH_LSIGN2 = 4'd8,
    PH_LMAG   = 4'd9,
    PH_LRAW   = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PARSE,
    ST_DRAIN_RD,
    ST_DRAIN_WR
  } state_t;

  typedef struct packed {
    logic [7:0] chunk_bits;
    logic [3:0] chunk_len;
    logic       row_start;
  } chunk_t;

  typedef struct packed {
    logic [2:0]  row_index;
    logic        half_index;
    logic [63:0] alpha_bytes;
    logic [2:0]  unused_bits;
    logic        bad_run;
    logic        end_of_block;
  } alpha_row_t;

  // Sequencer to parser.
  typedef struct packed {
    logic step;       // consume one bit this cycle
    logic bit_val;
    logic blk_clr;    // start a new block
    logic fault_clr;  // row start
  } parse_ctl_t;

  // Parser to sequencer.
  typedef struct packed {
    logic                  eob;
    logic                  wr_en;
    logic [POS_W-2:0]      wr_pos;
    logic [BYTE_W-1:0]     wr_level;
    logic                  fault;
  } parse_res_t;

endpackage
`default_nettype wire

FILE: rtl/arbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module arbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/arbd_bit_parser.sv
// One-bit-per-step run/level code parser with fill position and fault tracking.
`timescale 1ns / 1ps
`default_nettype none
module arbd_bit_parser (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire arbd_pkg::parse_ctl_t    ctl,
  output arbd_pkg::parse_res_t         res
);
  import arbd_pkg::*;

  phase_t            parse_phase, parse_phase_next;
  logic [7:0]        suffix_shift, suffix_shift_next;
  logic [3:0]        suffix_count, suffix_count_next;
  logic              level_negative, level_negative_next;
  logic [POS_W-1:0]  fill_position, fill_position_next;
  logic              fault_hold, fault_hold_next;

  logic [7:0]        shift_acc;
  logic [3:0]        count_inc;
  logic              run_go;
  logic [7:0]        run_val;
  logic              level_go;
  logic [7:0]        level_val;
  logic [POS_W:0]    run_sum;
  logic [7:0]        mag;

  always_comb begin
    parse_phase_next    = parse_phase;
    suffix_shift_next   = suffix_shift;
    suffix_count_next   = suffix_count;
    level_negative_next = level_negative;
    fill_position_next  = fill_position;
    fault_hold_next     = fault_hold;
    res                 = '0;
    run_go              = 1'b0;
    run_val             = '0;
    level_go            = 1'b0;
    level_val           = '0;
    run_sum             = '0;
    shift_acc = suffix_shift | (8'(ctl.bit_val) << suffix_count[2:0]);
    count_inc = suffix_count + 4'd1;
    mag       = shift_acc + 8'd2;

    if (ctl.step) begin
      unique case (parse_phase)
        PH_RUN0: begin
          if (ctl.bit_val) parse_phase_next = PH_RUN1;
          else run_go = 1'b1;
        end
        PH_RUN1: begin
          if (ctl.bit_val) begin
            parse_phase_next = PH_RUN11;
          end else begin
            suffix_shift_next = '0;
            suffix_count_next = '0;
            parse_phase_next  = PH_RSHORT;
          end
        end
        PH_RUN11: begin
          if (!ctl.bit_val) begin
            res.eob = 1'b1;
          end else begin
            suffix_shift_next = '0;
            suffix_count_next = '0;
            parse_phase_next  = PH_RLONG;
          end
        end
        PH_RSHORT: begin
          suffix_shift_next = shift_acc;
          suffix_count_next = count_inc;
          if (count_inc >= 4'd2) begin
            run_go  = 1'b1;
            run_val = shift_acc + 8'd1;
          end
        end
        PH_RLONG: begin
          suffix_shift_next = shift_acc;
          suffix_count_next = count_inc;
          if (count_inc >= 4'd7) begin
            run_go  = 1'b1;
            run_val = shift_acc;
          end
        end
        PH_LVL0: begin
          parse_phase_next = ctl.bit_val ? PH_LSIGN1 : PH_LVL00;
        end
        PH_LSIGN1: begin
          level_go  = 1'b1;
          level_val = ctl.bit_val ? 8'hFF : 8'h01;
        end
        PH_LVL00: begin
          if (ctl.bit_val) begin
            parse_phase_next = PH_LSIGN2;
          end else begin
            suffix_shift_next = '0;
            suffix_count_next = '0;
            parse_phase_next  = PH_LRAW;
          end
        end
        PH_LSIGN2: begin
          level_negative_next = ctl.bit_val;
          suffix_shift_next   = '0;
          suffix_count_next   = '0;
          parse_phase_next    = PH_LMAG;
        end
        PH_LMAG: begin
          suffix_shift_next = shift_acc;
          suffix_count_next = count_inc;
          if (count_inc >= 4'd2) begin
            level_go  = 1'b1;
            level_val = level_negative ? (8'd0 - mag) : mag;
          end
        end
        PH_LRAW: begin
          suffix_shift_next = shift_acc;
          suffix_count_next = count_inc;
          if (count_inc >= 4'd8) begin
            level_go  = 1'b1;
            level_val = shift_acc;
          end
        end
        default: begin
          parse_phase_next = PH_RUN0;
        end
      endcase
    end

    // A run that lands at or past the end of the block saturates and faults.
    if (run_go) begin
      run_sum = {1'b0, fill_position} + (POS_W + 1)'(run_val);
      if (run_sum >= (POS_W + 1)'(BLK_SIZE)) begin
        fault_hold_next    = 1'b1;
        fill_position_next = POS_W'(BLK_SIZE);
      end else begin
        fill_position_next = run_sum[POS_W-1:0];
      end
      parse_phase_next = PH_LVL0;
    end

    if (level_go) begin
      res.wr_en    = !fault_hold && !fill_position[POS_W-1];
      res.wr_pos   = fill_position[POS_W-2:0];
      res.wr_level = level_val;
      if (!fill_position[POS_W-1]) begin
        fill_position_next = fill_position + POS_W'(1);
      end
      parse_phase_next = PH_RUN0;
    end

    res.fault = fault_hold;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.blk_clr) begin
      parse_phase    <= PH_RUN0;
      suffix_shift   <= '0;
      suffix_count   <= '0;
      level_negative <= 1'b0;
      fill_position  <= '0;
    end else begin
      parse_phase    <= parse_phase_next;
      suffix_shift   <= suffix_shift_next;
      suffix_count   <= suffix_count_next;
      level_negative <= level_negative_next;
      fill_position  <= fill_position_next;
    end
    if (rst || ctl.fault_clr) begin
      fault_hold <= 1'b0;
    end else begin
      fault_hold <= fault_hold_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/alpha_rle_block_decoder.sv
// Top level: chunk sequencer, coefficient store, column predictors and row output.
//
//   channel    dir   handshake                   payload
//   chunk      in    chunk_valid / chunk_ready   arbd_pkg::chunk_t
//   alpha      out   alpha_valid / alpha_ready   arbd_pkg::alpha_row_t
//
// A chunk is accepted, then its valid bits are decoded in order by the single bit
// parser. An end-of-block code starts a drain of 16 half rows, each a registered
// coefficient RAM read, then a predictor update.
// Reset is synchronous; the coefficient store is tracked by per-entry valid bits
// that all clear together, so no clearing pass is needed.
// A stalled alpha beat holds the drain; chunks are taken again once draining ends.
`timescale 1ns / 1ps
`default_nettype none
module alpha_rle_block_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 chunk_valid,
  output logic                      chunk_ready,
  input  wire arbd_pkg::chunk_t     chunk,
  output logic                      alpha_valid,
  input  wire logic                 alpha_ready,
  output arbd_pkg::alpha_row_t      alpha_row
);
  import arbd_pkg::*;

  state_t                     state, state_next;
  logic [7:0]                 bits;
  logic [3:0]                 len;
  logic [LANE_W-1:0]          bit_idx;
  logic [2:0]                 left;
  logic [WORD_W-1:0]          drain_idx;
  logic [WORDS-1:0][LANES-1:0] coeff_valid;
  logic [LANES-1:0]           rd_valid;
  logic [1:0][LANES-1:0][BYTE_W-1:0] column_alpha;
  logic [LANES-1:0][BYTE_W-1:0] rd_data;
  logic [LANES-1:0][BYTE_W-1:0] new_half;

  parse_ctl_t                 ctl;
  parse_res_t                 res;

  logic                       accept;
  logic                       last_bit;
  logic                       out_free;
  logic                       drain_wr;
  logic                       drain_done;
  logic [3:0]                 len_clamped;

  assign accept      = chunk_valid && chunk_ready;
  assign len_clamped = (chunk.chunk_len > MAX_LEN) ? MAX_LEN : chunk.chunk_len;
  assign last_bit    = ({1'b0, bit_idx} + 4'd1) == len;
  assign out_free    = !alpha_valid || alpha_ready;
  assign drain_wr    = (state == ST_DRAIN_WR);
  assign drain_done  = drain_wr && (drain_idx == WORD_W'(WORDS - 1));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && len_clamped != 4'd0) state_next = ST_PARSE;
      end
      ST_PARSE: begin
        if (res.eob) state_next = ST_DRAIN_RD;
        else if (last_bit) state_next = ST_IDLE;
      end
      ST_DRAIN_RD: begin
        if (out_free) state_next = ST_DRAIN_WR;
      end
      ST_DRAIN_WR: begin
        state_next = drain_done ? ST_IDLE : ST_DRAIN_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    chunk_ready   = 1'b0;
    ctl           = '0;
    unique case (state)
      ST_IDLE: begin
        // The block is always ready here, so a valid beat is accepted.
        chunk_ready   = 1'b1;
        ctl.fault_clr = chunk_valid && chunk.row_start;
      end
      ST_PARSE: begin
        ctl.step    = 1'b1;
        ctl.bit_val = bits[bit_idx];
      end
      ST_DRAIN_RD: begin
      end
      ST_DRAIN_WR: begin
        ctl.blk_clr = drain_done;
      end
      default: begin
      end
    endcase
  end

  arbd_bit_parser u_parser (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .res (res)
  );

  // One byte lane per column within a half row; address is the half row.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    arbd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WORDS)
    ) u_coeff (
      .clk     (clk),
      .wr_en   (res.wr_en && (res.wr_pos[LANE_W-1:0] == LANE_W'(k))),
      .wr_addr (res.wr_pos[POS_W-2:LANE_W]),
      .wr_data (res.wr_level),
      .rd_addr (drain_idx),
      .rd_data (rd_data[k])
    );

    // Entries never written since the block began read as zero.
    assign new_half[k] = column_alpha[drain_idx[0]][k]
                         - (rd_valid[k] ? rd_data[k] : BYTE_W'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      bit_idx     <= '0;
      drain_idx   <= '0;
      coeff_valid <= '0;
      alpha_valid <= 1'b0;
      column_alpha <= {(2 * LANES){ALPHA_INIT}};
    end else begin
      state <= state_next;

      if (accept) begin
        bit_idx <= '0;
        if (chunk.row_start) column_alpha <= {(2 * LANES){ALPHA_INIT}};
      end else if (state == ST_PARSE) begin
        bit_idx <= bit_idx + LANE_W'(1);
      end

      if (res.wr_en) begin
        coeff_valid[res.wr_pos[POS_W-2:LANE_W]][res.wr_pos[LANE_W-1:0]] <= 1'b1;
      end

      if (alpha_valid && alpha_ready) alpha_valid <= 1'b0;

      if (drain_wr) begin
        alpha_valid <= 1'b1;
        drain_idx   <= drain_idx + WORD_W'(1);
        if (!res.fault) column_alpha[drain_idx[0]] <= new_half;
        if (drain_done) coeff_valid <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= coeff_valid[drain_idx];
    if (accept) begin
      bits <= chunk.chunk_bits;
      len  <= len_clamped;
    end
    if (state == ST_PARSE && res.eob) begin
      left <= 3'(len - {1'b0, bit_idx} - 4'd1);
    end
    if (drain_wr) begin
      alpha_row.row_index    <= drain_idx[WORD_W-1:1];
      alpha_row.half_index   <= drain_idx[0];
      alpha_row.alpha_bytes  <= res.fault ? 64'd0 : new_half;
      alpha_row.unused_bits  <= left;
      alpha_row.bad_run      <= res.fault;
      alpha_row.end_of_block <= drain_done;
    end
  end

endmodule
`default_nettype wire
